>>> sv/pcpc_pkg.sv
`timescale 1ns / 1ps

package pcpc_pkg;

    // fixed-point widths
    localparam int TEMP_W  = 16;
    localparam int ERR_W   = 17;
    localparam int DIFF_W  = 18;
    localparam int TIME_W  = 32;
    localparam int INTEG_W = 26;
    localparam int PROD_W  = 50;
    localparam int ISUM_W  = 51;
    localparam int KP_W    = 32;
    localparam int NUM_W   = 41;
    localparam int TOT_W   = 43;
    localparam int DRIVE_W = 7;
    localparam int CNT_W   = 6;

    // gains and limits, scaled to units of 1/512000 percent
    localparam logic signed [15:0]        KP_GAIN      = 16'sd30000;
    localparam logic [23:0]               KD_GAIN      = 24'd10000000;
    localparam logic [INTEG_W-1:0]        INTEG_MAX    = 26'd51200000;
    localparam logic [TIME_W-1:0]         DT_DEFAULT   = 32'd1000;
    localparam logic [TEMP_W-1:0]         TARGET_RESET = 16'd6400;
    localparam logic [TOT_W-2:0]          DRIVE_FULL   = 42'd51200000;
    localparam logic [DRIVE_W-1:0]        DRIVE_MAX    = 7'd100;
    // floor(x / 125) = (x * 16778) >> 21 for x below 12500
    localparam logic [14:0]               RECIP_125    = 15'd16778;
    localparam int                        RECIP_SHIFT  = 21;

    // datapath operations
    typedef logic [3:0] op_t;
    localparam op_t OP_NOP   = 4'd0;
    localparam op_t OP_LOAD  = 4'd1;
    localparam op_t OP_DTFIX = 4'd2;
    localparam op_t OP_MULI  = 4'd3;
    localparam op_t OP_INTEG = 4'd4;
    localparam op_t OP_DMUL  = 4'd5;
    localparam op_t OP_DIVGO = 4'd6;
    localparam op_t OP_DFIX  = 4'd7;
    localparam op_t OP_TOTAL = 4'd8;
    localparam op_t OP_SCALE = 4'd9;
    localparam op_t OP_DONE  = 4'd10;
    localparam op_t OP_STOP  = 4'd11;

    // sequencer jump conditions
    typedef logic [1:0] jc_t;
    localparam jc_t JC_NEXT       = 2'd0;
    localparam jc_t JC_IF_INVALID = 2'd1;
    localparam jc_t JC_WHILE_DIV  = 2'd2;
    localparam jc_t JC_FINISH     = 2'd3;

    typedef logic [3:0] uaddr_t;

    // microcode entry points
    localparam uaddr_t UA_LOAD     = 4'd0;
    localparam uaddr_t UA_DIV_WAIT = 4'd6;
    localparam uaddr_t UA_DONE     = 4'd10;
    localparam uaddr_t UA_STOP     = 4'd11;

    typedef struct packed {
        op_t    op;
        jc_t    jc;
        uaddr_t tgt;
    } ucode_t;

    typedef struct packed {
        logic invalid;
        logic div_busy;
        logic out_free;
    } dp_status_t;

    // control store
    function automatic ucode_t ucode_rom(input uaddr_t addr);
        ucode_t w;
        unique case (addr)
            4'd0:    w = '{op: OP_LOAD,  jc: JC_IF_INVALID, tgt: UA_STOP};
            4'd1:    w = '{op: OP_DTFIX, jc: JC_NEXT,       tgt: UA_LOAD};
            4'd2:    w = '{op: OP_MULI,  jc: JC_NEXT,       tgt: UA_LOAD};
            4'd3:    w = '{op: OP_INTEG, jc: JC_NEXT,       tgt: UA_LOAD};
            4'd4:    w = '{op: OP_DMUL,  jc: JC_NEXT,       tgt: UA_LOAD};
            4'd5:    w = '{op: OP_DIVGO, jc: JC_NEXT,       tgt: UA_LOAD};
            4'd6:    w = '{op: OP_NOP,   jc: JC_WHILE_DIV,  tgt: UA_DIV_WAIT};
            4'd7:    w = '{op: OP_DFIX,  jc: JC_NEXT,       tgt: UA_LOAD};
            4'd8:    w = '{op: OP_TOTAL, jc: JC_NEXT,       tgt: UA_LOAD};
            4'd9:    w = '{op: OP_SCALE, jc: JC_NEXT,       tgt: UA_LOAD};
            4'd10:   w = '{op: OP_DONE,  jc: JC_FINISH,     tgt: UA_DONE};
            4'd11:   w = '{op: OP_STOP,  jc: JC_FINISH,     tgt: UA_STOP};
            default: w = '{op: OP_STOP,  jc: JC_FINISH,     tgt: UA_STOP};
        endcase
        return w;
    endfunction

endpackage

>>> sv/pcpc_divider.sv
`timescale 1ns / 1ps

module pcpc_divider
    import pcpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  dividend,
    input  logic [TIME_W-1:0] divisor,
    output logic              busy,
    output logic [NUM_W-1:0]  quotient,
    output logic              rem_nz
);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [TIME_W-1:0] den_reg, den_next;
    logic [TIME_W:0]   rem_sh;
    logic              ge;

    // one restoring step per cycle
    assign rem_sh = {rem_reg, quo_reg[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], ge};
            rem_next = ge ? TIME_W'(rem_sh - {1'b0, den_reg}) : rem_sh[TIME_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
    assign rem_nz   = rem_reg != '0;

endmodule

>>> sv/pcpc_datapath.sv
`timescale 1ns / 1ps

module pcpc_datapath
    import pcpc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  op_t                      op,
    input  logic                     accept,
    input  logic signed [TEMP_W-1:0] sample_temperature,
    input  logic                     sample_valid,
    input  logic [TIME_W-1:0]        time_ms,
    input  logic                     cfg_write,
    input  logic signed [TEMP_W-1:0] cfg_target,
    input  logic                     out_stall,
    output logic                     out_valid,
    output logic [DRIVE_W-1:0]       drive_percent,
    output logic                     stop_motor,
    output dp_status_t               status
);

    // configuration and persistent state
    logic signed [TEMP_W-1:0] target_reg;
    logic signed [ERR_W-1:0]  prev_err_reg;
    logic [INTEG_W-1:0]       integ_acc_reg;
    logic [TIME_W-1:0]        last_time_reg;

    // latched sample
    logic signed [TEMP_W-1:0] temp_reg;
    logic                     valid_reg;
    logic [TIME_W-1:0]        now_reg;

    // working registers
    logic [TIME_W-1:0]        dt_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [INTEG_W-1:0]       integ_reg;
    logic signed [KP_W-1:0]   kp_reg;
    logic signed [TOT_W-1:0]  partial_reg;
    logic [NUM_W-1:0]         num_reg;
    logic                     dneg_reg;
    logic signed [TOT_W-1:0]  deriv_reg;
    logic signed [TOT_W-1:0]  total_reg;
    logic [DRIVE_W-1:0]       drive_calc_reg;

    // output register
    logic                     out_valid_reg;
    logic [DRIVE_W-1:0]       drive_reg;
    logic                     stop_reg;

    logic                     out_free;
    logic signed [PROD_W-1:0] prod_full;
    logic signed [ISUM_W-1:0] isum;
    logic signed [KP_W-1:0]   kp_full;
    logic [DIFF_W-1:0]        abs_diff;
    logic [NUM_W-1:0]         num_full;
    logic [NUM_W-1:0]         div_quo;
    logic                     div_rem_nz;
    logic                     div_busy;
    logic [TOT_W-1:0]         qmag;
    logic [28:0]              scale_prod;
    logic                     tot_neg;
    logic                     tot_big;

    assign out_free = !out_valid_reg || !out_stall;

    // arithmetic for the individual steps
    assign prod_full  = err_reg * $signed({1'b0, dt_reg});
    assign isum       = $signed({{(ISUM_W-INTEG_W){1'b0}}, integ_acc_reg})
                      + $signed({prod_reg[PROD_W-1], prod_reg});
    assign kp_full    = err_reg * KP_GAIN;
    assign abs_diff   = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);
    assign num_full   = NUM_W'(abs_diff[ERR_W-1:0] * KD_GAIN);
    assign qmag       = TOT_W'(div_quo) + TOT_W'(div_rem_nz);
    assign tot_neg    = total_reg[TOT_W-1];
    assign tot_big    = !tot_neg && (total_reg[TOT_W-2:0] >= DRIVE_FULL);
    assign scale_prod = total_reg[25:12] * RECIP_125;

    pcpc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (op == OP_DIVGO),
        .dividend (num_reg),
        .divisor  (dt_reg),
        .busy     (div_busy),
        .quotient (div_quo),
        .rem_nz   (div_rem_nz)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= TARGET_RESET;
            prev_err_reg  <= '0;
            integ_acc_reg <= '0;
            last_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                target_reg <= cfg_target;
            end
            if ((op == OP_DONE || op == OP_STOP) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            // commit state on a finished valid sample
            if (op == OP_DONE && out_free)
            begin
                prev_err_reg  <= err_reg;
                integ_acc_reg <= integ_reg;
                last_time_reg <= now_reg;
            end
        end
    end

    // sample latch and step datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            temp_reg  <= sample_temperature;
            valid_reg <= sample_valid;
            now_reg   <= time_ms;
        end
        unique case (op)
            OP_NOP:
            begin
            end
            OP_LOAD:
            begin
                dt_reg  <= now_reg - last_time_reg;
                err_reg <= ERR_W'($signed({target_reg[TEMP_W-1], target_reg})
                                - $signed({temp_reg[TEMP_W-1], temp_reg}));
            end
            OP_DTFIX:
            begin
                if (dt_reg == '0)
                begin
                    dt_reg <= DT_DEFAULT;
                end
                diff_reg <= DIFF_W'($signed({err_reg[ERR_W-1], err_reg})
                                  - $signed({prev_err_reg[ERR_W-1], prev_err_reg}));
            end
            OP_MULI:
            begin
                prod_reg <= prod_full;
            end
            OP_INTEG:
            begin
                // clamp the integral to its window
                if (isum[ISUM_W-1])
                begin
                    integ_reg <= '0;
                end
                else if (isum > $signed({{(ISUM_W-INTEG_W){1'b0}}, INTEG_MAX}))
                begin
                    integ_reg <= INTEG_MAX;
                end
                else
                begin
                    integ_reg <= isum[INTEG_W-1:0];
                end
                kp_reg <= kp_full;
            end
            OP_DMUL:
            begin
                num_reg     <= num_full;
                dneg_reg    <= diff_reg[DIFF_W-1];
                partial_reg <= $signed({{(TOT_W-KP_W){kp_reg[KP_W-1]}}, kp_reg})
                             + $signed({{(TOT_W-INTEG_W){1'b0}}, integ_reg});
            end
            OP_DIVGO:
            begin
            end
            OP_DFIX:
            begin
                // floor division for a negative derivative
                if (dneg_reg)
                begin
                    deriv_reg <= -$signed(qmag);
                end
                else
                begin
                    deriv_reg <= $signed(TOT_W'(div_quo));
                end
            end
            OP_TOTAL:
            begin
                total_reg <= partial_reg + deriv_reg;
            end
            OP_SCALE:
            begin
                if (tot_neg)
                begin
                    drive_calc_reg <= '0;
                end
                else if (tot_big)
                begin
                    drive_calc_reg <= DRIVE_MAX;
                end
                else
                begin
                    drive_calc_reg <= scale_prod[RECIP_SHIFT+DRIVE_W-1:RECIP_SHIFT];
                end
            end
            OP_DONE:
            begin
                if (out_free)
                begin
                    drive_reg <= drive_calc_reg;
                    stop_reg  <= 1'b0;
                end
            end
            OP_STOP:
            begin
                if (out_free)
                begin
                    drive_reg <= '0;
                    stop_reg  <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign status.invalid  = !valid_reg;
    assign status.div_busy = div_busy;
    assign status.out_free = out_free;

    assign out_valid     = out_valid_reg;
    assign drive_percent = drive_reg;
    assign stop_motor    = stop_reg;

endmodule

>>> sv/pcpc_sequencer.sv
`timescale 1ns / 1ps

module pcpc_sequencer
    import pcpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output logic       busy,
    output op_t        op
);

    logic   busy_reg, busy_next;
    uaddr_t pc_reg, pc_next;
    ucode_t uword;

    assign uword = ucode_rom(pc_reg);

    // step counter and conditional jumps
    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                pc_next   = UA_LOAD;
            end
        end
        else
        begin
            unique case (uword.jc)
                JC_NEXT:
                begin
                    pc_next = pc_reg + 1'b1;
                end
                JC_IF_INVALID:
                begin
                    pc_next = status.invalid ? uword.tgt : uaddr_t'(pc_reg + 1'b1);
                end
                JC_WHILE_DIV:
                begin
                    pc_next = status.div_busy ? uword.tgt : uaddr_t'(pc_reg + 1'b1);
                end
                JC_FINISH:
                begin
                    if (status.out_free)
                    begin
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        pc_next = uword.tgt;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= UA_LOAD;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    assign busy = busy_reg;
    assign op   = busy_reg ? uword.op : OP_NOP;

endmodule

>>> sv/pid_clamped_power_controller.sv
`timescale 1ns / 1ps

// PID temperature-to-power controller with a clamped integral. Each sample
// transaction yields exactly one result: an invalid sample gives stop_motor = 1
// and drive_percent = 0 without touching the controller state, a valid one
// gives the clamped PID drive in 0..100 percent. A microcoded sequencer walks
// a twelve-step control store over a shared datapath; for a valid sample the
// serial divider for the derivative term produces one quotient bit per cycle
// over 41 bits. One sample is processed at a time; the next one is accepted
// as soon as the previous result sits in the output register, even if it has
// not been taken yet. The user must write the setpoint through the cfg channel
// only while the block is idle; the block itself does not enforce this. The
// setpoint resets to 25.0 degrees.

module pid_clamped_power_controller
    import pcpc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // sample channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [TEMP_W-1:0] sample_temperature,
    input  logic                     sample_valid,
    input  logic [TIME_W-1:0]        time_ms,
    // result channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [DRIVE_W-1:0]       drive_percent,
    output logic                     stop_motor,
    // setpoint write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic signed [TEMP_W-1:0] target_temperature
);

    logic       seq_busy;
    logic       accept;
    op_t        op;
    dp_status_t status;

    assign in_stall  = seq_busy;
    assign accept    = in_valid && !seq_busy;
    assign cfg_ready = 1'b1;

    pcpc_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .status (status),
        .busy   (seq_busy),
        .op     (op)
    );

    pcpc_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .op                 (op),
        .accept             (accept),
        .sample_temperature (sample_temperature),
        .sample_valid       (sample_valid),
        .time_ms            (time_ms),
        .cfg_write          (cfg_valid && cfg_ready),
        .cfg_target         (target_temperature),
        .out_stall          (out_stall),
        .out_valid          (out_valid),
        .drive_percent      (drive_percent),
        .stop_motor         (stop_motor),
        .status             (status)
    );

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
    import pcpc_pkg::*;

    // controller scaling: drive counts in units of 1/512000 percent
    localparam longint INTEG_CEIL = 64'sd51200000;
    localparam longint P_GAIN     = 64'sd30000;
    localparam longint D_GAIN     = 64'sd10000000;
    localparam longint DRIVE_UNIT = 64'sd512000;
    localparam int     FULL_DRIVE = 100;
    localparam int     PHASES     = 8;
    localparam int     PHASE_LEN  = 231;
    localparam int     SWEEP_LEN  = 19;

    typedef struct {
        logic [DRIVE_W-1:0] drive;
        logic               stop;
    } power_t;

    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic                     ok;
        logic [TIME_W-1:0]        stamp;
        bit                       fixed;
        logic [DRIVE_W-1:0]       drive;
        logic                     stop;
    } sweep_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [TEMP_W-1:0] sample_temperature;
    logic                     sample_valid;
    logic [TIME_W-1:0]        time_ms;
    logic                     out_valid;
    logic                     out_stall;
    logic [DRIVE_W-1:0]       drive_percent;
    logic                     stop_motor;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic signed [TEMP_W-1:0] target_temperature;

    // controller state mirrored by the testbench
    logic signed [TEMP_W-1:0] ctl_setpoint;
    int                       ctl_prev_err;
    longint                   ctl_integral;
    logic [TIME_W-1:0]        ctl_last_stamp;

    power_t            pending_power[$];
    int                error_count;
    int                burst_left;
    logic [TIME_W-1:0] clock_now;
    int                stall_run;
    int                stall_mode;

    // directed sweep at the reset setpoint of 25.0 degrees
    sweep_row_t sweep_rows [SWEEP_LEN] = '{
        // failed read with every stamp bit set
        '{16'sh7FFF, 1'b0, 32'hFFFF_FFFF, 1'b1, 7'd0,   1'b1},
        // coldest reading at a zero time step saturates the drive
        '{16'sh8000, 1'b1, 32'd0,         1'b1, 7'd100, 1'b0},
        '{16'sh8000, 1'b1, 32'd0,         1'b1, 7'd100, 1'b0},
        '{16'sd6400, 1'b1, 32'd2000,      1'b0, 7'd0,   1'b0},
        // hottest reading over a near-full wrap empties the integral
        '{16'sh7FFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 7'd0,   1'b0},
        '{16'sd6400, 1'b1, 32'hFFFF_FFFF, 1'b0, 7'd0,   1'b0},
        '{16'sd6656, 1'b1, 32'd4,         1'b0, 7'd0,   1'b0},
        '{16'sd6144, 1'b1, 32'd6,         1'b0, 7'd0,   1'b0},
        '{16'sh8000, 1'b0, 32'd0,         1'b1, 7'd0,   1'b1},
        '{16'sd6144, 1'b1, 32'd2006,      1'b0, 7'd0,   1'b0},
        // long steps below the setpoint drive the integral to its ceiling
        '{16'sd4000, 1'b1, 32'd62006,     1'b0, 7'd0,   1'b0},
        '{16'sd4000, 1'b1, 32'd122006,    1'b0, 7'd0,   1'b0},
        '{16'sd4000, 1'b1, 32'd182006,    1'b0, 7'd0,   1'b0},
        '{16'sd4000, 1'b1, 32'd242006,    1'b0, 7'd0,   1'b0},
        '{16'sd9000, 1'b1, 32'd342006,    1'b0, 7'd0,   1'b0},
        '{16'sd6400, 1'b1, 32'd344006,    1'b0, 7'd0,   1'b0},
        '{16'sd0,    1'b1, 32'd344007,    1'b0, 7'd0,   1'b0},
        '{16'shFFFF, 1'b1, 32'd346007,    1'b0, 7'd0,   1'b0},
        '{16'sd0,    1'b0, 32'd0,         1'b1, 7'd0,   1'b1}
    };

    pid_clamped_power_controller dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .sample_temperature (sample_temperature),
        .sample_valid       (sample_valid),
        .time_ms            (time_ms),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .drive_percent      (drive_percent),
        .stop_motor         (stop_motor),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .target_temperature (target_temperature)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic report_error(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // pid step on one sample, advances the mirrored state on a valid one
    function automatic power_t control_step(input logic signed [TEMP_W-1:0] temp,
                                            input logic ok,
                                            input logic [TIME_W-1:0] stamp);
        power_t            res;
        logic [TIME_W-1:0] dt;
        longint            dt_l;
        int                err;
        longint            integ;
        longint            num;
        longint            deriv;
        longint            total;
        res.drive = '0;
        res.stop  = 1'b1;
        if (!ok)
            return res;
        dt = stamp - ctl_last_stamp;
        if (dt == '0)
            dt = DT_DEFAULT;
        dt_l = dt;
        err = int'(ctl_setpoint) - int'(temp);
        integ = ctl_integral + longint'(err) * dt_l;
        if (integ > INTEG_CEIL)
            integ = INTEG_CEIL;
        else if (integ < 0)
            integ = 0;
        num = D_GAIN * longint'(err - ctl_prev_err);
        deriv = num / dt_l;
        if ((num % dt_l) != 0 && num < 0)
            deriv = deriv - 1;
        total = P_GAIN * longint'(err) + integ + deriv;
        res.stop = 1'b0;
        if (total < 0)
            res.drive = '0;
        else if (total / DRIVE_UNIT > FULL_DRIVE)
            res.drive = DRIVE_W'(FULL_DRIVE);
        else
            res.drive = DRIVE_W'(total / DRIVE_UNIT);
        ctl_integral   = integ;
        ctl_prev_err   = err;
        ctl_last_stamp = stamp;
        return res;
    endfunction

    // one sample transaction in bursts with random gaps, entered and left at negedge
    task automatic send_sample(input logic signed [TEMP_W-1:0] temp, input logic ok,
                               input logic [TIME_W-1:0] stamp, input bit fixed,
                               input power_t fixed_res);
        int     gap;
        power_t res;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        in_valid           = 1'b1;
        sample_temperature = temp;
        sample_valid       = ok;
        time_ms            = stamp;
        do
            @(posedge clk);
        while (in_stall);
        res = control_step(temp, ok, stamp);
        pending_power.push_back(fixed ? fixed_res : res);
        burst_left--;
        @(negedge clk);
    endtask

    // hold the sender until every result is back
    task automatic drain_results();
        in_valid   = 1'b0;
        burst_left = 0;
        while (pending_power.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_setpoint(input logic signed [TEMP_W-1:0] value);
        cfg_valid          = 1'b1;
        target_temperature = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        ctl_setpoint = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic signed [TEMP_W-1:0] near_temp(input int center, input int span);
        int t;
        t = center + $urandom_range(0, 2 * span) - span;
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        return TEMP_W'(t);
    endfunction

    // random sample shaped around the setpoint and a plausible clock
    task automatic send_random_sample();
        logic signed [TEMP_W-1:0] temp;
        logic [TIME_W-1:0]        stamp;
        power_t                   none;
        int                       pick;
        none = '{drive: '0, stop: 1'b0};
        pick = $urandom_range(0, 99);
        if (pick < 20)
            temp = TEMP_W'($urandom);
        else if (pick < 45)
            temp = near_temp(int'(ctl_setpoint), 300);
        else
            temp = near_temp(int'(ctl_setpoint), 2000);
        // failed read: any stamp, no clock advance
        if ($urandom_range(0, 9) == 0)
        begin
            send_sample(temp, 1'b0, $urandom, 1'b0, none);
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60)
            clock_now = clock_now + $urandom_range(1500, 2500);
        else if (pick < 70)
            clock_now = clock_now;
        else if (pick < 80)
            clock_now = clock_now + $urandom_range(1, 20);
        else if (pick < 90)
            clock_now = $urandom;
        else
            clock_now = clock_now + $urandom_range(100000, 2000000);
        stamp = clock_now;
        send_sample(temp, 1'b1, stamp, 1'b0, none);
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = (stall_mode == 3) ? $urandom_range(1, 30) : $urandom_range(5, 60);
        end
        stall_run--;
        case (stall_mode)
            0:       out_stall = 1'b0;
            1:       out_stall = $urandom_range(0, 1);
            2:       out_stall = ($urandom_range(0, 3) == 0);
            default: out_stall = 1'b1;
        endcase
    end

    // result checker
    always @(posedge clk)
    begin
        power_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_power.size() == 0)
                report_error($sformatf("unexpected result drive %0d stop %0b",
                                       drive_percent, stop_motor));
            else
            begin
                want = pending_power.pop_front();
                if (drive_percent !== want.drive)
                    report_error($sformatf("drive_percent got %0d want %0d",
                                           drive_percent, want.drive));
                if (stop_motor !== want.stop)
                    report_error($sformatf("stop_motor got %0b want %0b",
                                           stop_motor, want.stop));
            end
        end
    end

    initial
    begin
        power_t                   typed;
        logic signed [TEMP_W-1:0] setpt;
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        sample_temperature = '0;
        sample_valid       = 1'b0;
        time_ms            = '0;
        out_stall          = 1'b0;
        cfg_valid          = 1'b0;
        target_temperature = '0;
        error_count        = 0;
        burst_left         = 0;
        stall_run          = 0;
        stall_mode         = 0;
        ctl_setpoint       = TARGET_RESET;
        ctl_prev_err       = 0;
        ctl_integral       = 0;
        ctl_last_stamp     = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed sweep
        for (int i = 0; i < SWEEP_LEN; i++)
        begin
            typed = '{drive: sweep_rows[i].drive, stop: sweep_rows[i].stop};
            send_sample(sweep_rows[i].temp, sweep_rows[i].ok, sweep_rows[i].stamp,
                        sweep_rows[i].fixed, typed);
        end
        clock_now = ctl_last_stamp;

        // random phases, each at its own setpoint
        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            case (p)
                0:       setpt = 16'sh7FFF;
                1:       setpt = 16'sh8000;
                2:       setpt = 16'sd0;
                3:       setpt = TARGET_RESET;
                default: setpt = TEMP_W'($urandom);
            endcase
            write_setpoint(setpt);
            for (int n = 0; n < PHASE_LEN; n++)
                send_random_sample();
        end

        drain_results();
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
